>>> design/x86_16_instruction_length_decoder_assert.svh
// ---------------------------------------------------------------------------
// x86_16_instruction_length_decoder_assert.svh
// Assertion macros shared by the length decoder sources.
// ---------------------------------------------------------------------------
`ifndef X86_16_INSTRUCTION_LENGTH_DECODER_ASSERT_SVH
`define X86_16_INSTRUCTION_LENGTH_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define X86IL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define X86IL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/x86il_pkg.sv
// ---------------------------------------------------------------------------
// x86il_pkg
// Types, opcode constants and decode functions for the 8086 length decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package x86il_pkg;

    // Decode plan of the instruction being collected
    typedef struct packed {
        logic       has_modrm;
        logic [1:0] disp_len;   // 0, 1 or 2 bytes
        logic [2:0] imm_len;    // 0, 1, 2 or 4 bytes
        logic       sx;         // immediate byte is sign-extended
        logic       rel;        // relative branch
        logic       undef;      // invalid or unsupported opcode
        logic [2:0] total;      // instruction length in bytes
    } t_plan;

    // Opcodes that the decode functions test by name
    localparam logic [7:0] OP_GRP3_B = 8'hF6;
    localparam logic [7:0] OP_GRP3_W = 8'hF7;
    localparam logic [7:0] OP_GRP4   = 8'hFE;
    localparam logic [7:0] OP_GRP5   = 8'hFF;
    localparam logic [7:0] OP_ESC    = 8'h0F;

    // modrm fields
    localparam logic [1:0] MOD_MEM0  = 2'b00;
    localparam logic [1:0] MOD_DISP8 = 2'b01;
    localparam logic [1:0] MOD_DISP16 = 2'b10;
    localparam logic [2:0] RM_DIRECT = 3'b110;

    // Plan from the opcode byte alone
    function automatic t_plan plan_opcode(input logic [7:0] op);
        t_plan p;
        p = '0;
        if (op[7:6] == 2'b00) begin
            if (op == OP_ESC) begin
                p.undef = 1'b1;
            end else if (op[2:0] < 3'd4) begin
                p.has_modrm = 1'b1;
            end else if (op[2:0] == 3'd4) begin
                p.imm_len = 3'd1;
            end else if (op[2:0] == 3'd5) begin
                p.imm_len = 3'd2;
            end
        end else if (op < 8'h60) begin
            // inc, dec, push, pop: one byte
        end else if (op < 8'h70) begin
            p.undef = 1'b1;
        end else if (op < 8'h80) begin
            p.imm_len = 3'd1;
            p.sx      = 1'b1;
            p.rel     = 1'b1;
        end else if (op < 8'h90) begin
            p.has_modrm = 1'b1;
            if (op == 8'h80 || op == 8'h82) begin
                p.imm_len = 3'd1;
            end else if (op == 8'h81) begin
                p.imm_len = 3'd2;
            end else if (op == 8'h83) begin
                p.imm_len = 3'd1;
                p.sx      = 1'b1;
            end
        end else if (op < 8'hA0) begin
            if (op == 8'h9A) begin
                p.imm_len = 3'd4;
            end
        end else if (op < 8'hB0) begin
            if (op <= 8'hA3 || op == 8'hA9) begin
                p.imm_len = 3'd2;
            end else if (op == 8'hA8) begin
                p.imm_len = 3'd1;
            end
        end else if (op < 8'hC0) begin
            p.imm_len = op[3] ? 3'd2 : 3'd1;
        end else begin
            case (op)
                8'hC0, 8'hC1, 8'hC8, 8'hC9, 8'hF1,
                8'hD8, 8'hD9, 8'hDA, 8'hDB,
                8'hDC, 8'hDD, 8'hDE, 8'hDF: begin
                    p.undef = 1'b1;
                end
                8'hC2, 8'hCA: begin
                    p.imm_len = 3'd2;
                end
                8'hC4, 8'hC5, 8'hD0, 8'hD1, 8'hD2, 8'hD3,
                8'hF6, 8'hF7, 8'hFE, 8'hFF: begin
                    p.has_modrm = 1'b1;
                end
                8'hC6: begin
                    p.has_modrm = 1'b1;
                    p.imm_len   = 3'd1;
                end
                8'hC7: begin
                    p.has_modrm = 1'b1;
                    p.imm_len   = 3'd2;
                end
                8'hCD, 8'hD4, 8'hD5, 8'hE4, 8'hE5, 8'hE6, 8'hE7: begin
                    p.imm_len = 3'd1;
                end
                8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hEB: begin
                    p.imm_len = 3'd1;
                    p.sx      = 1'b1;
                    p.rel     = 1'b1;
                end
                8'hE8, 8'hE9: begin
                    p.imm_len = 3'd2;
                    p.rel     = 1'b1;
                end
                8'hEA: begin
                    p.imm_len = 3'd4;
                end
                default: begin
                end
            endcase
        end
        p.total = 3'd1 + {2'b00, p.has_modrm} + p.imm_len;
        return p;
    endfunction

    // Plan refined by the modrm byte
    function automatic t_plan plan_modrm(input logic [7:0] op, input logic [7:0] m,
                                         input t_plan cur);
        t_plan      p;
        logic [2:0] rg;
        p  = cur;
        rg = m[5:3];
        if ((m[7:6] == MOD_MEM0 && m[2:0] == RM_DIRECT) || m[7:6] == MOD_DISP16) begin
            p.disp_len = 2'd2;
        end else if (m[7:6] == MOD_DISP8) begin
            p.disp_len = 2'd1;
        end else begin
            p.disp_len = 2'd0;
        end
        if (op == OP_GRP3_B || op == OP_GRP3_W) begin
            if (rg < 3'd2) begin
                p.imm_len = op[0] ? 3'd2 : 3'd1;
            end
        end else if (op == OP_GRP4 || op == OP_GRP5) begin
            if ((op == OP_GRP4 && rg >= 3'd2 && rg <= 3'd6) || rg == 3'd7) begin
                p.undef    = 1'b1;
                p.disp_len = 2'd0;
            end else if (rg == 3'd3 || rg == 3'd5) begin
                // far call/jmp through memory: a word follows modrm
                p.disp_len = 2'd0;
                p.imm_len  = 3'd2;
            end
        end
        p.total = 3'd2 + {1'b0, p.disp_len} + p.imm_len;
        return p;
    endfunction

endpackage

`default_nettype wire

>>> design/x86il_decode.sv
// ---------------------------------------------------------------------------
// x86il_decode
// Picks the instruction plan for the current byte: from the opcode on the
// first byte, refined by modrm on the second, otherwise carried over.
// ---------------------------------------------------------------------------
`default_nettype none

module x86il_decode (
    input  wire logic [7:0]    i_byte,
    input  wire logic [7:0]    i_opcode,
    input  wire logic          i_first,
    input  wire logic          i_modrm_step,
    input  wire x86il_pkg::t_plan i_plan,
    output x86il_pkg::t_plan   o_plan
);
    import x86il_pkg::*;

    // plan select
    always_comb begin
        if (i_first) begin
            o_plan = plan_opcode(i_byte);
        end else if (i_modrm_step) begin
            o_plan = plan_modrm(i_opcode, i_byte, i_plan);
        end else begin
            o_plan = i_plan;
        end
    end

endmodule

`default_nettype wire

>>> design/x86_16_instruction_length_decoder.sv
// ---------------------------------------------------------------------------
// x86_16_instruction_length_decoder
// Splits an 8086 code byte stream into instructions and reports each one.
// ---------------------------------------------------------------------------
// Usage:
//   Code bytes enter on i_code_valid / o_code_ready, one byte per item.
//   Each byte is captured in an input register; when it advances it is
//   decoded against the phase state and, when it is the last byte of an
//   instruction, the instruction's result item is loaded into the output
//   register (o_res_valid / i_res_ready). Bytes that do not end an
//   instruction give no result item.
//   Throughput: one byte per cycle while the output register is empty or
//   being taken, set by the single decode step between input and output
//   registers.
//   Stall: while the output register holds an untaken item, the input
//   register keeps its byte and o_code_ready drops once it is full too.
//   Configuration: i_start_offset written on i_cfg_valid / o_cfg_ready
//   (always ready) sets the offset of the next byte and drops any partly
//   received instruction. Write only while the block is idle.
//   Reset: both registers empty, waiting for an opcode, offset zero.
// ---------------------------------------------------------------------------
`default_nettype none

`include "x86_16_instruction_length_decoder_assert.svh"

module x86_16_instruction_length_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_start_offset,
    // code bytes
    input  wire logic        i_code_valid,
    output logic             o_code_ready,
    input  wire logic [7:0]  i_code_byte,
    // results
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [7:0]       o_opcode_byte,
    output logic [7:0]       o_modrm_byte,
    output logic             o_has_modrm,
    output logic [15:0]      o_displacement,
    output logic [15:0]      o_immediate,
    output logic [15:0]      o_far_segment,
    output logic [2:0]       o_length,
    output logic [15:0]      o_instr_offset,
    output logic [15:0]      o_branch_target,
    output logic             o_target_valid,
    output logic             o_undefined_op
);
    import x86il_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // phase machine and collected fields
    logic [2:0]  r_phase;
    t_plan       r_plan;
    logic [7:0]  r_op;
    logic [7:0]  r_modrm;
    logic [15:0] r_disp;
    logic [15:0] r_imm;
    logic [15:0] r_seg;
    logic [15:0] r_cur;
    logic [15:0] r_start;

    // output stage
    logic        r_out_valid;
    logic [7:0]  r_o_op;
    logic [7:0]  r_o_modrm;
    logic        r_o_has_modrm;
    logic [15:0] r_o_disp;
    logic [15:0] r_o_imm;
    logic [15:0] r_o_seg;
    logic [2:0]  r_o_len;
    logic [15:0] r_o_start;
    logic [15:0] r_o_target;
    logic        r_o_rel;
    logic        r_o_undef;

    // next values
    logic [7:0]  n_op;
    logic [7:0]  n_modrm;
    logic [15:0] n_disp;
    logic [15:0] n_imm;
    logic [15:0] n_seg;
    logic [15:0] n_start;

    logic        w_first;
    logic        w_modrm_step;
    t_plan       w_plan;
    logic [2:0]  w_k;
    logic [2:0]  w_j;
    logic [2:0]  w_phase_inc;
    logic        w_done;
    logic        w_advance;
    logic        w_code_fire;
    logic        w_cfg_fire;
    logic [15:0] w_disp_out;
    logic [15:0] w_imm_out;
    logic [15:0] w_target;

    // handshakes
    assign w_advance    = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_code_ready = !r_in_valid || w_advance;
    assign w_code_fire  = i_code_valid && o_code_ready;
    assign o_cfg_ready  = 1'b1;
    assign w_cfg_fire   = i_cfg_valid;

    assign w_first      = (r_phase == 3'd0);
    assign w_modrm_step = (r_phase == 3'd1) && r_plan.has_modrm;

    x86il_decode u_decode (
        .i_byte       (r_in_byte),
        .i_opcode     (r_op),
        .i_first      (w_first),
        .i_modrm_step (w_modrm_step),
        .i_plan       (r_plan),
        .o_plan       (w_plan)
    );

    // byte position past opcode and modrm, then past displacement
    assign w_k = r_phase - 3'd1 - {2'b00, r_plan.has_modrm};
    assign w_j = w_k - {1'b0, r_plan.disp_len};

    // merge the byte into the collected fields
    always_comb begin
        n_op    = r_op;
        n_modrm = r_modrm;
        n_disp  = r_disp;
        n_imm   = r_imm;
        n_seg   = r_seg;
        n_start = r_start;
        if (w_first) begin
            n_op    = r_in_byte;
            n_modrm = 8'h00;
            n_disp  = 16'h0000;
            n_imm   = 16'h0000;
            n_seg   = 16'h0000;
            n_start = r_cur;
        end else if (w_modrm_step) begin
            n_modrm = r_in_byte;
        end else if (w_k < {1'b0, r_plan.disp_len}) begin
            if (w_k[0]) begin
                n_disp[15:8] = r_in_byte;
            end else begin
                n_disp[7:0] = r_in_byte;
            end
        end else if (w_j < 3'd2) begin
            if (w_j[0]) begin
                n_imm[15:8] = r_in_byte;
            end else begin
                n_imm[7:0] = r_in_byte;
            end
        end else begin
            if (w_j[0]) begin
                n_seg[15:8] = r_in_byte;
            end else begin
                n_seg[7:0] = r_in_byte;
            end
        end
    end

    // end of instruction test
    assign w_phase_inc = r_phase + 3'd1;
    assign w_done      = (w_phase_inc >= w_plan.total);

    // result fields
    assign w_disp_out = (w_plan.disp_len == 2'd1) ? {{8{n_disp[7]}}, n_disp[7:0]} : n_disp;
    assign w_imm_out  = w_plan.sx ? {{8{n_imm[7]}}, n_imm[7:0]} : n_imm;
    assign w_target   = n_start + {13'd0, w_plan.total} + w_imm_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= 3'd0;
            r_plan      <= '0;
            r_cur       <= 16'h0000;
        end else begin
            if (w_code_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance && w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_fire) begin
                r_phase <= 3'd0;
                r_cur   <= i_start_offset;
            end else if (w_advance) begin
                r_phase <= w_done ? 3'd0 : w_phase_inc;
                r_plan  <= w_plan;
                r_cur   <= r_cur + 16'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_code_fire) begin
            r_in_byte <= i_code_byte;
        end
        if (w_advance) begin
            r_op    <= n_op;
            r_modrm <= n_modrm;
            r_disp  <= n_disp;
            r_imm   <= n_imm;
            r_seg   <= n_seg;
            r_start <= n_start;
        end
        if (w_advance && w_done) begin
            r_o_op        <= n_op;
            r_o_modrm     <= w_plan.has_modrm ? n_modrm : 8'h00;
            r_o_has_modrm <= w_plan.has_modrm;
            r_o_disp      <= w_disp_out;
            r_o_imm       <= w_imm_out;
            r_o_seg       <= n_seg;
            r_o_len       <= w_plan.total;
            r_o_start     <= n_start;
            r_o_target    <= w_plan.rel ? w_target : 16'h0000;
            r_o_rel       <= w_plan.rel;
            r_o_undef     <= w_plan.undef;
        end
    end

    // outputs
    assign o_res_valid     = r_out_valid;
    assign o_opcode_byte   = r_o_op;
    assign o_modrm_byte    = r_o_modrm;
    assign o_has_modrm     = r_o_has_modrm;
    assign o_displacement  = r_o_disp;
    assign o_immediate     = r_o_imm;
    assign o_far_segment   = r_o_seg;
    assign o_length        = r_o_len;
    assign o_instr_offset  = r_o_start;
    assign o_branch_target = r_o_target;
    assign o_target_valid  = r_o_rel;
    assign o_undefined_op  = r_o_undef;

    // checks
    `X86IL_ASSERT_NOW(a_len_range, i_clk, i_rst_n, r_out_valid,
        (r_o_len >= 3'd1) && (r_o_len <= 3'd6), "result length out of range")
    `X86IL_ASSERT_NOW(a_phase_below_total, i_clk, i_rst_n, r_phase != 3'd0,
        r_phase < r_plan.total, "phase machine passed instruction end")
    `X86IL_ASSERT_NOW(a_rel_no_modrm, i_clk, i_rst_n, r_out_valid && r_o_rel,
        !r_o_has_modrm && (r_o_disp == 16'h0000), "relative branch with modrm fields")
    `X86IL_ASSERT_NEXT(a_offset_step, i_clk, i_rst_n, w_advance && !w_cfg_fire,
        r_cur == $past(r_cur) + 16'd1, "offset did not advance with byte")

endmodule

`default_nettype wire
